@@ src/fnpl_pkg.sv @@
// Shared types, widths and constants of the filterbank noise, PCAN and log channel core.
package fnpl_pkg;

  // Channel count and table depths
  localparam int CHANNELS         = 40;
  localparam int GAIN_TABLE_DEPTH = 132;
  localparam int LOG_TABLE_DEPTH  = 130;
  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GT_AW = $clog2(GAIN_TABLE_DEPTH);
  localparam int LT_AW = $clog2(LOG_TABLE_DEPTH);

  // Field widths
  localparam int ENERGY_W = 53;
  localparam int ROOT_W   = 28;

  // Serial multiplier widths: signed multiplicand, unsigned multiplier, signed product
  localparam int MA_W = 34;
  localparam int MB_W = 32;
  localparam int MP_W = 66;

  // Arithmetic constants
  localparam int LOG_E_SCALE = 45426;
  localparam int LOG_RND     = 32768;
  localparam int GAIN_RND    = 16384;
  localparam int SHRINK_KNEE = 8192;
  localparam int SHRINK_OFF  = 64;

  // Input actions
  localparam logic [1:0] ACT_PROC  = 2'd0;
  localparam logic [1:0] ACT_GAIN  = 2'd1;
  localparam logic [1:0] ACT_LOG   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_EVEN_SMOOTH = 2'd0;
  localparam logic [1:0] CFG_ODD_SMOOTH  = 2'd1;
  localparam logic [1:0] CFG_MIN_SIGNAL  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         channel;
    logic [52:0]        energy;
    logic [3:0]         norm_shift;
    logic [7:0]         table_index;
    logic signed [31:0] table_word;
  } in_t;

  typedef struct packed {
    logic [15:0] feature;
    logic [5:0]  feature_channel;
  } out_t;

  // Request to the serial multiplier
  typedef struct packed {
    logic                   start;
    logic signed [MA_W-1:0] a;
    logic [MB_W-1:0]        b;
    logic signed [MP_W-1:0] init;
  } mul_req_t;

endpackage

@@ src/fnpl_ram.sv @@
// Generic single write port RAM with a registered read port.
module fnpl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/fnpl_sqrt.sv @@
// Bit-pair serial integer square root, rounded half up.
module fnpl_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fnpl_pkg::ENERGY_W-1:0] value,
  output logic                          busy,
  output logic [fnpl_pkg::ROOT_W-1:0]   root
);

  logic                          busy_r, busy_nxt;
  logic [fnpl_pkg::ENERGY_W-1:0] v_r, v_nxt;
  logic [fnpl_pkg::ENERGY_W-1:0] r_r, r_nxt;
  logic [fnpl_pkg::ENERGY_W-1:0] bit_r, bit_nxt;
  logic [fnpl_pkg::ENERGY_W:0]   trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  // One result bit per cycle, two remainder bits per step
  always_comb begin
    busy_nxt = busy_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = value;
      r_nxt    = '0;
      bit_nxt  = {1'b1, {(fnpl_pkg::ENERGY_W-1){1'b0}}};
    end else if (busy_r) begin
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if ({1'b0, v_r} >= trial) begin
          v_nxt = v_r - trial[fnpl_pkg::ENERGY_W-1:0];
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  // Round half up on the leftover remainder
  assign busy = busy_r;
  assign root = (v_r > r_r) ? (r_r[fnpl_pkg::ROOT_W-1:0] + 1'b1)
                            : r_r[fnpl_pkg::ROOT_W-1:0];

endmodule

@@ src/fnpl_smul.sv @@
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier, added start value.
module fnpl_smul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fnpl_pkg::mul_req_t               req,
  output logic                             busy,
  output logic signed [fnpl_pkg::MP_W-1:0] prod
);

  logic                             busy_r, busy_nxt;
  logic signed [fnpl_pkg::MP_W-1:0] a_r, a_nxt;
  logic [fnpl_pkg::MB_W-1:0]        b_r, b_nxt;
  logic signed [fnpl_pkg::MP_W-1:0] acc_r, acc_nxt;

  // One multiplier bit per cycle; stops once the remaining bits are zero
  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      a_nxt    = fnpl_pkg::MP_W'(req.a);
      b_nxt    = req.b;
      acc_nxt  = req.init;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r <<< 1;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

@@ src/filterbank_noise_pcan_log_channel_core.sv @@
// Top level: per-channel noise reduction, PCAN gain and log scale of filterbank energies.
//
//   Channel  Handshake               Word
//   in       in_valid / in_ready     fnpl_pkg::in_t  (action, channel, energy, ...)
//   out      out_valid / out_ready   fnpl_pkg::out_t (feature, feature_channel)
//   cfg      cfg_valid / cfg_ready   cfg_index (2 bits), cfg_data (15 bits)
//
// A table write or noise clear leaves the core idle. A process word runs through the
// bit-pair root, the passes through the shared bit-serial multiplier and the two
// one-bit normalizing shifts.
// Reset is synchronous and active low; it clears the state, config registers and valid bits.
// A finished word waits in the output register while the next input word is taken.
module filterbank_noise_pcan_log_channel_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fnpl_pkg::in_t   in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output fnpl_pkg::out_t  out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_EST, S_FLOOR, S_GSMALL, S_GNORM, S_GRD, S_GMUL1, S_GMUL2,
    S_SNR, S_SQ, S_LNORM, S_LRD0, S_LRD1, S_LMUL1, S_LMUL2, S_OUT
  } state_t;

  localparam int MP_W = fnpl_pkg::MP_W;
  localparam int MA_W = fnpl_pkg::MA_W;
  localparam int CH_AW = fnpl_pkg::CH_AW;

  state_t state_r, state_nxt;
  logic [14:0] even_r, odd_r, min_r;
  logic [fnpl_pkg::CHANNELS-1:0] valid_r, valid_nxt;
  logic [5:0]  ch_r, ch_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [27:0] sig_r, sig_nxt;
  logic [31:0] scaled_r, scaled_nxt;
  logic [31:0] est_r, est_nxt;
  logic [31:0] sig2_r, sig2_nxt;
  logic [31:0] norm_r, norm_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [9:0]  frac_r, frac_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [31:0] c0_r, c0_nxt;
  logic [15:0] lfrac_r, lfrac_nxt;
  logic [4:0]  whole_r, whole_nxt;
  logic [15:0] feat_r, feat_nxt;
  logic        out_valid_r, out_valid_nxt;
  fnpl_pkg::out_t out_r;
  logic        out_load;

  logic in_fire, cfg_fire, proc_fire;
  logic sq_start, sq_busy;
  logic [27:0] sq_root;
  fnpl_pkg::mul_req_t mul_req;
  logic mul_busy;
  logic signed [MP_W-1:0] mul_p;

  logic nram_we;
  logic [31:0] nram_q;
  logic gram_re, lram_re;
  logic [fnpl_pkg::GT_AW-1:0] gram_raddr;
  logic [fnpl_pkg::LT_AW-1:0] lram_raddr;
  logic [15:0] gram_q;
  logic [31:0] lram_q;

  logic [CH_AW-1:0] ch_idx;
  logic [27:0] root_sh;
  logic [31:0] scaled_w, ne_w, floor_w, clamp_w, diff_w, sub_w, m_w, logx_w;
  logic [14:0] smooth_w;
  logic [5:0]  iv_w;
  logic [7:0]  off_w;
  logic signed [MP_W-1:0] p_sh5, p_sh15, p_sh16, snr_w, abs_w, shr_big, shr_sq, shr_w;
  logic log_go;
  logic signed [MA_W-1:0] gq_sx, res1_w, gain_w, dlog_w, log2v_w;
  logic [31:0] t32;
  logic signed [32:0] s33;
  logic [16:0] t17;
  logic [15:0] feat_w;

  // Handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign proc_fire = in_fire && (in_word.action == fnpl_pkg::ACT_PROC);

  // Root and multiplier units
  fnpl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (in_word.energy),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  fnpl_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .busy  (mul_busy),
    .prod  (mul_p)
  );

  // Noise estimates, gain table and log table
  fnpl_ram #(.WIDTH(32), .DEPTH(fnpl_pkg::CHANNELS)) u_noise_ram (
    .clk     (clk),
    .wr_en   (nram_we),
    .wr_addr (ch_idx),
    .wr_data (est_nxt),
    .rd_en   (proc_fire),
    .rd_addr (in_word.channel[CH_AW-1:0]),
    .rd_data (nram_q)
  );

  fnpl_ram #(.WIDTH(16), .DEPTH(fnpl_pkg::GAIN_TABLE_DEPTH)) u_gain_ram (
    .clk     (clk),
    .wr_en   (in_fire && (in_word.action == fnpl_pkg::ACT_GAIN) &&
              (in_word.table_index < 8'(fnpl_pkg::GAIN_TABLE_DEPTH))),
    .wr_addr (in_word.table_index[fnpl_pkg::GT_AW-1:0]),
    .wr_data (in_word.table_word[15:0]),
    .rd_en   (gram_re),
    .rd_addr (gram_raddr),
    .rd_data (gram_q)
  );

  fnpl_ram #(.WIDTH(32), .DEPTH(fnpl_pkg::LOG_TABLE_DEPTH)) u_log_ram (
    .clk     (clk),
    .wr_en   (in_fire && (in_word.action == fnpl_pkg::ACT_LOG) &&
              (in_word.table_index < 8'(fnpl_pkg::LOG_TABLE_DEPTH))),
    .wr_addr (in_word.table_index[fnpl_pkg::LT_AW-1:0]),
    .wr_data (in_word.table_word),
    .rd_en   (lram_re),
    .rd_addr (lram_raddr),
    .rd_data (lram_q)
  );

  // Noise stage datapath
  assign ch_idx   = ch_r[CH_AW-1:0];
  assign root_sh  = sq_root >> shift_r;
  assign scaled_w = {root_sh[21:0], 10'b0};
  assign ne_w     = valid_r[ch_idx] ? nram_q : 32'd0;
  assign smooth_w = ch_r[0] ? odd_r : even_r;
  assign floor_w  = mul_p[45:14];
  assign clamp_w  = (est_r > scaled_r) ? scaled_r : est_r;
  assign diff_w   = scaled_r - clamp_w;
  assign sub_w    = {10'b0, diff_w[31:10]};

  // Gain stage datapath
  assign iv_w   = 6'd32 - {1'b0, lz_r};
  assign off_w  = {iv_w, 2'b00} - 8'd6;
  assign p_sh5  = mul_p >>> 5;
  assign p_sh15 = mul_p >>> 15;
  assign p_sh16 = mul_p >>> 16;
  assign gq_sx  = {{(MA_W-16){gram_q[15]}}, gram_q};
  assign res1_w = $signed(p_sh5[MA_W-1:0]) + $signed({{13{gram_q[15]}}, gram_q, 5'b0});
  assign gain_w = $signed(p_sh15[MA_W-1:0]) + gq_sx;

  // Shrink curve
  assign snr_w   = mul_p >>> 6;
  assign abs_w   = (snr_w < 0) ? -snr_w : snr_w;
  assign m_w     = (abs_w > $signed(MP_W'(33'h0_FFFF_FFFF))) ? 32'hFFFF_FFFF : abs_w[31:0];
  assign shr_big = (snr_w >>> 6) - MP_W'(fnpl_pkg::SHRINK_OFF);
  assign shr_sq  = mul_p >>> 20;
  assign shr_w   = (state_r == S_SQ) ? shr_sq : shr_big;
  assign logx_w  = {shr_w[28:0], 3'b0};
  assign log_go  = (shr_w > 0) && (logx_w != 32'd0);

  // Log stage datapath
  assign dlog_w  = $signed({{2{lram_q[31]}}, lram_q}) - $signed({{2{c0_r[31]}}, c0_r});
  assign log2v_w = $signed({13'b0, whole_r, 16'b0}) + $signed({18'b0, lfrac_r}) +
                   $signed({{2{c0_r[31]}}, c0_r}) + $signed(p_sh16[MA_W-1:0]);
  assign t32     = {mul_p[41:16], 6'b0};
  assign s33     = $signed({t32[31], t32}) + 33'sd32768;
  assign t17     = s33[32:16];
  assign feat_w  = t17[16] ? 16'd0 : t17[15:0];

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    shift_nxt  = shift_r;
    sig_nxt    = sig_r;
    scaled_nxt = scaled_r;
    est_nxt    = est_r;
    sig2_nxt   = sig2_r;
    norm_nxt   = norm_r;
    lz_nxt     = lz_r;
    frac_nxt   = frac_r;
    off_nxt    = off_r;
    c0_nxt     = c0_r;
    lfrac_nxt  = lfrac_r;
    whole_nxt  = whole_r;
    feat_nxt   = feat_r;
    sq_start   = 1'b0;
    mul_req    = '0;
    nram_we    = 1'b0;
    gram_re    = 1'b0;
    gram_raddr = '0;
    lram_re    = 1'b0;
    lram_raddr = '0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (proc_fire && ({1'b0, in_word.channel} < 7'(fnpl_pkg::CHANNELS))) begin
          ch_nxt    = in_word.channel;
          shift_nxt = in_word.norm_shift;
          sq_start  = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!sq_busy) begin
          sig_nxt       = root_sh;
          scaled_nxt    = scaled_w;
          mul_req.start = 1'b1;
          mul_req.a     = $signed({2'b0, scaled_w}) - $signed({2'b0, ne_w});
          mul_req.b     = {17'b0, smooth_w};
          mul_req.init  = $signed({20'b0, ne_w, 14'b0});
          state_nxt     = S_EST;
        end
      end
      S_EST: begin
        if (!mul_busy) begin
          est_nxt       = mul_p[45:14];
          nram_we       = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = $signed({6'b0, sig_r});
          mul_req.b     = {17'b0, min_r};
          state_nxt     = S_FLOOR;
        end
      end
      S_FLOOR: begin
        if (!mul_busy) begin
          sig2_nxt = (sub_w > floor_w) ? sub_w : floor_w;
          if (est_r <= 32'd2) begin
            gram_re    = 1'b1;
            gram_raddr = {6'b0, est_r[1:0]};
            state_nxt  = S_GSMALL;
          end else begin
            norm_nxt  = est_r;
            lz_nxt    = '0;
            state_nxt = S_GNORM;
          end
        end
      end
      S_GSMALL: begin
        mul_req.start = 1'b1;
        mul_req.a     = gq_sx;
        mul_req.b     = sig2_r;
        state_nxt     = S_SNR;
      end
      S_GNORM: begin
        if (norm_r[31]) begin
          frac_nxt   = norm_r[30:21];
          off_nxt    = off_w;
          gram_re    = 1'b1;
          gram_raddr = off_w + 8'd2;
          state_nxt  = S_GRD;
        end else begin
          norm_nxt = norm_r << 1;
          lz_nxt   = lz_r + 5'd1;
        end
      end
      S_GRD: begin
        mul_req.start = 1'b1;
        mul_req.a     = gq_sx;
        mul_req.b     = {22'b0, frac_r};
        gram_re       = 1'b1;
        gram_raddr    = off_r + 8'd1;
        state_nxt     = S_GMUL1;
      end
      S_GMUL1: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = res1_w;
          mul_req.b     = {22'b0, frac_r};
          mul_req.init  = MP_W'(fnpl_pkg::GAIN_RND);
          gram_re       = 1'b1;
          gram_raddr    = off_r;
          state_nxt     = S_GMUL2;
        end
      end
      S_GMUL2: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = gain_w;
          mul_req.b     = sig2_r;
          state_nxt     = S_SNR;
        end
      end
      S_SNR, S_SQ: begin
        if (!mul_busy) begin
          if ((state_r == S_SNR) && (snr_w < MP_W'(fnpl_pkg::SHRINK_KNEE))) begin
            mul_req.start = 1'b1;
            mul_req.a     = $signed({2'b0, m_w});
            mul_req.b     = m_w;
            state_nxt     = S_SQ;
          end else if (log_go) begin
            norm_nxt  = logx_w;
            lz_nxt    = '0;
            state_nxt = S_LNORM;
          end else begin
            feat_nxt  = 16'd0;
            state_nxt = S_OUT;
          end
        end
      end
      S_LNORM: begin
        if (norm_r[31]) begin
          whole_nxt  = ~lz_r;
          lfrac_nxt  = norm_r[30:15];
          lram_re    = 1'b1;
          lram_raddr = {1'b0, norm_r[30:24]};
          state_nxt  = S_LRD0;
        end else begin
          norm_nxt = norm_r << 1;
          lz_nxt   = lz_r + 5'd1;
        end
      end
      S_LRD0: begin
        c0_nxt     = lram_q;
        lram_re    = 1'b1;
        lram_raddr = {1'b0, lfrac_r[15:9]} + 8'd1;
        state_nxt  = S_LRD1;
      end
      S_LRD1: begin
        mul_req.start = 1'b1;
        mul_req.a     = dlog_w;
        mul_req.b     = {23'b0, lfrac_r[8:0]};
        state_nxt     = S_LMUL1;
      end
      S_LMUL1: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = log2v_w;
          mul_req.b     = 32'(fnpl_pkg::LOG_E_SCALE);
          mul_req.init  = MP_W'(fnpl_pkg::LOG_RND);
          state_nxt     = S_LMUL2;
        end
      end
      S_LMUL2: begin
        if (!mul_busy) begin
          feat_nxt  = feat_w;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Noise valid bits: cleared together, set on each estimate write
  always_comb begin
    valid_nxt = valid_r;
    if (in_fire && (in_word.action == fnpl_pkg::ACT_CLEAR)) begin
      valid_nxt = '0;
    end
    if (nram_we) begin
      valid_nxt[ch_idx] = 1'b1;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // State, control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      even_r      <= '0;
      odd_r       <= '0;
      min_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          fnpl_pkg::CFG_EVEN_SMOOTH: even_r <= cfg_data;
          fnpl_pkg::CFG_ODD_SMOOTH:  odd_r  <= cfg_data;
          fnpl_pkg::CFG_MIN_SIGNAL:  min_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    ch_r     <= ch_nxt;
    shift_r  <= shift_nxt;
    sig_r    <= sig_nxt;
    scaled_r <= scaled_nxt;
    est_r    <= est_nxt;
    sig2_r   <= sig2_nxt;
    norm_r   <= norm_nxt;
    lz_r     <= lz_nxt;
    frac_r   <= frac_nxt;
    off_r    <= off_nxt;
    c0_r     <= c0_nxt;
    lfrac_r  <= lfrac_nxt;
    whole_r  <= whole_nxt;
    feat_r   <= feat_nxt;
    if (out_load) begin
      out_r.feature         <= feat_r;
      out_r.feature_channel <= ch_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  // A new word is only taken with both serial units at rest
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!mul_busy && !sq_busy))
    else $error("input word taken while a serial unit is busy");

  // Estimates are only written for channels that exist
  a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
    nram_we |-> ({1'b0, ch_r} < 7'(fnpl_pkg::CHANNELS)))
    else $error("noise estimate write beyond the channel count");

  // A clear word leaves every estimate reading as zero
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.action == fnpl_pkg::ACT_CLEAR)) |=> (valid_r == '0))
    else $error("noise valid bits not cleared");

  // A written estimate is marked valid
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    nram_we |=> valid_r[$past(ch_idx)])
    else $error("written estimate not marked valid");

  // The output register never overwrites a word not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the filterbank noise, PCAN and log channel core.
`timescale 1ns / 100ps

// Scoreboard: predicts each feature from the accepted words and checks the outputs.
class feature_scoreboard;
  logic [14:0]      even_sm, odd_sm, min_sig;
  logic [31:0]      noise_est [fnpl_pkg::CHANNELS];
  shortint          gain_tab [fnpl_pkg::GAIN_TABLE_DEPTH];
  int               log_tab [fnpl_pkg::LOG_TABLE_DEPTH];
  fnpl_pkg::out_t   pending_features [$];
  int               mismatches;

  function new();
    even_sm = 0; odd_sm = 0; min_sig = 0; mismatches = 0;
    foreach (noise_est[i]) noise_est[i] = 0;
    foreach (gain_tab[i]) gain_tab[i] = 0;
    foreach (log_tab[i]) log_tab[i] = 0;
  endfunction

  // Floor division by a power of two.
  function longint floor_shift(longint a, int k);
    longint unsigned m;
    if (a >= 0) return a >>> k;
    m = longint'(0) - a;
    return -longint'((m + ((64'd1 << k) - 1)) >> k);
  endfunction

  function int bits_used(logic [31:0] v);
    int n;
    n = 0;
    while (v != 0) begin n++; v = v >> 1; end
    return n;
  endfunction

  // Integer square root rounded half up.
  function longint unsigned rounded_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 52;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin v = v - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    return (v > r) ? r + 1 : r;
  endfunction

  function longint pcan_gain(logic [31:0] x);
    int iv, off;
    logic [31:0] frac;
    longint res;
    if (x <= 2) return longint'(gain_tab[x]);
    iv = bits_used(x);
    off = 4 * iv - 6;
    frac = ((iv < 11) ? (x << (11 - iv)) : (x >> (iv - 11))) & 32'h3ff;
    res = floor_shift(longint'(gain_tab[off + 2]) * longint'(frac), 5);
    res = res + longint'(gain_tab[off + 1]) * 32;
    res = res * longint'(frac);
    res = floor_shift(res + 16384, 15);
    return res + longint'(gain_tab[off]);
  endfunction

  function longint shrink_curve(longint x);
    longint unsigned m;
    if (x < 8192) begin
      m = (x < 0) ? longint'(0) - x : x;
      if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      return longint'((m * m) >> 20);
    end
    return floor_shift(x, 6) - 64;
  endfunction

  function longint natural_log(logic [31:0] x);
    int whole;
    logic [31:0] frac, seg;
    longint c0, c1, rel, l2, le;
    logic [63:0] t;
    int s;
    if (x == 0) return 0;
    whole = bits_used(x) - 1;
    frac = x - (32'd1 << whole);
    if (whole < 16) frac = frac << (16 - whole);
    else frac = frac >> (whole - 16);
    seg = (frac >> 9) & 32'h7f;
    c0 = longint'(log_tab[seg]);
    c1 = longint'(log_tab[seg + 1]);
    rel = floor_shift((c1 - c0) * (longint'(frac) - 512 * longint'(seg)), 16);
    l2 = (longint'(whole) << 16) + longint'(frac) + c0 + rel;
    le = floor_shift(45426 * l2 + 32768, 16);
    t = le << 6;
    s = t[31:0];
    return floor_shift(longint'(s) + 32768, 16);
  endfunction

  function void write_reg(logic [1:0] idx, logic [14:0] val);
    case (idx)
      fnpl_pkg::CFG_EVEN_SMOOTH: even_sm = val;
      fnpl_pkg::CFG_ODD_SMOOTH:  odd_sm = val;
      fnpl_pkg::CFG_MIN_SIGNAL:  min_sig = val;
      default: ;
    endcase
  endfunction

  // Applies one accepted input word and queues its feature, if any.
  function void note_word(fnpl_pkg::in_t w);
    longint sig, sm, est_sum, g, snr, corr, lg;
    logic [63:0] t;
    logic [31:0] scaled, est, clamped, floor_v, sub;
    fnpl_pkg::out_t o;
    case (w.action)
      fnpl_pkg::ACT_GAIN: begin
        if (w.table_index < fnpl_pkg::GAIN_TABLE_DEPTH)
          gain_tab[w.table_index] = w.table_word[15:0];
        return;
      end
      fnpl_pkg::ACT_LOG: begin
        if (w.table_index < fnpl_pkg::LOG_TABLE_DEPTH) log_tab[w.table_index] = w.table_word;
        return;
      end
      fnpl_pkg::ACT_CLEAR: begin
        foreach (noise_est[i]) noise_est[i] = 0;
        return;
      end
      default: ;
    endcase
    if (w.channel >= fnpl_pkg::CHANNELS) return;

    sig = longint'(rounded_sqrt(64'(w.energy)) >> w.norm_shift);
    sm = w.channel[0] ? longint'(odd_sm) : longint'(even_sm);
    t = sig << 10;
    scaled = t[31:0];
    est_sum = longint'(scaled) * sm + longint'(noise_est[w.channel]) * (16384 - sm);
    t = floor_shift(est_sum, 14);
    est = t[31:0];
    noise_est[w.channel] = est;
    clamped = (est > scaled) ? scaled : est;
    t = floor_shift(sig * longint'(min_sig), 14);
    floor_v = t[31:0];
    sub = (scaled - clamped) >> 10;
    sig = longint'((sub > floor_v) ? sub : floor_v);

    g = pcan_gain(est);
    snr = floor_shift(sig * g, 6);
    corr = shrink_curve(snr) * 8;
    t = corr;
    lg = (corr > 1) ? natural_log(t[31:0]) : 0;
    if (lg > 65535) lg = 65535;
    if (lg < 0) lg = 0;
    o.feature = lg[15:0];
    o.feature_channel = w.channel;
    pending_features.push_back(o);
  endfunction

  function void check_feature(fnpl_pkg::out_t got);
    fnpl_pkg::out_t exp_o;
    if (pending_features.size() == 0) begin
      $display("%0t: unexpected feature, expected none, actual %0d ch %0d",
               $time, got.feature, got.feature_channel);
      mismatches++;
      return;
    end
    exp_o = pending_features.pop_front();
    if (got.feature !== exp_o.feature) begin
      $display("%0t: feature mismatch, expected %0d, actual %0d",
               $time, exp_o.feature, got.feature);
      mismatches++;
    end
    if (got.feature_channel !== exp_o.feature_channel) begin
      $display("%0t: channel mismatch, expected %0d, actual %0d",
               $time, exp_o.feature_channel, got.feature_channel);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 300;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  fnpl_pkg::in_t in_word;
  fnpl_pkg::out_t out_word;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  feature_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int cycles;

  filterbank_noise_pcan_log_channel_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check accepted features, then stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_feature(out_word);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one word, idling at random first; valid stays high into the next word.
  task automatic send_word(fnpl_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Waits for every pending feature, then lets ignored words finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic fnpl_pkg::in_t make_word(logic [1:0] act, int ch, logic [52:0] e, int sh,
                                              int idx, int wd);
    fnpl_pkg::in_t w;
    w.action = act; w.channel = 6'(ch); w.energy = e; w.norm_shift = 4'(sh);
    w.table_index = 8'(idx); w.table_word = wd;
    return w;
  endfunction

  function automatic logic [52:0] rand_energy();
    logic [63:0] e;
    e = {$urandom, $urandom};
    e = e >> $urandom_range(11, 63);
    return e[52:0];
  endfunction

  // Random word: mostly valid channels, with ignored channels, table rewrites and clears.
  function automatic fnpl_pkg::in_t rand_word();
    int r;
    fnpl_pkg::in_t w;
    r = $urandom_range(99);
    w = make_word(fnpl_pkg::ACT_PROC, $urandom_range(0, fnpl_pkg::CHANNELS - 1), rand_energy(),
                  $urandom_range(0, 15), $urandom_range(0, 255), $urandom);
    if (r >= 82 && r < 88) w.channel = 6'($urandom_range(fnpl_pkg::CHANNELS, 63));
    else if (r >= 88 && r < 93) w.action = fnpl_pkg::ACT_GAIN;
    else if (r >= 93 && r < 98) w.action = fnpl_pkg::ACT_LOG;
    else if (r >= 98) w.action = fnpl_pkg::ACT_CLEAR;
    return w;
  endfunction

  task automatic run_phase(int idle, int stall, int n, logic [14:0] ev, logic [14:0] od,
                           logic [14:0] mn);
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_cfg(fnpl_pkg::CFG_EVEN_SMOOTH, ev);
    write_cfg(fnpl_pkg::CFG_ODD_SMOOTH, od);
    write_cfg(fnpl_pkg::CFG_MIN_SIGNAL, mn);
    repeat (n) send_word(rand_word());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_word = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = fnpl_pkg::CFG_EVEN_SMOOTH; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load both tables completely so no unwritten entry is ever read.
    for (int i = 0; i < fnpl_pkg::GAIN_TABLE_DEPTH; i++)
      send_word(make_word(fnpl_pkg::ACT_GAIN, 0, 0, 0, i, $urandom));
    for (int i = 0; i < fnpl_pkg::LOG_TABLE_DEPTH; i++)
      send_word(make_word(fnpl_pkg::ACT_LOG, 0, 0, 0, i, $urandom_range(0, 65535) - 32768));

    // Directed words: field extremes, ignored channels and writes, clear.
    drain();
    write_cfg(fnpl_pkg::CFG_EVEN_SMOOTH, 15'd16384);
    write_cfg(fnpl_pkg::CFG_ODD_SMOOTH, 15'd655);
    write_cfg(fnpl_pkg::CFG_MIN_SIGNAL, 15'd0);
    send_word(make_word(fnpl_pkg::ACT_PROC, 0, '0, 0, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 39, '1, 0, 255, -1));
    send_word(make_word(fnpl_pkg::ACT_PROC, 1, '1, 15, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 2, 53'd3, 0, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 40, '1, 0, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 63, 53'd12345, 0, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_GAIN, 0, 0, 0, 132, 32'h7fff_ffff));
    send_word(make_word(fnpl_pkg::ACT_GAIN, 0, 0, 0, 255, 32'h8000_0000));
    send_word(make_word(fnpl_pkg::ACT_LOG, 0, 0, 0, 130, -1));
    send_word(make_word(fnpl_pkg::ACT_GAIN, 0, 0, 0, 131, 32'h0001_8000));
    send_word(make_word(fnpl_pkg::ACT_PROC, 0, 53'd1 << 40, 3, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_CLEAR, 63, '1, 15, 255, -1));
    send_word(make_word(fnpl_pkg::ACT_PROC, 0, 53'd1 << 40, 3, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 5, 53'd999999999, 7, 0, 0));

    // Smoothing above one, then the zero, unity and random settings, with each idling mix.
    drain();
    write_cfg(fnpl_pkg::CFG_EVEN_SMOOTH, 15'h7fff);
    write_cfg(fnpl_pkg::CFG_ODD_SMOOTH, 15'h7fff);
    write_cfg(fnpl_pkg::CFG_MIN_SIGNAL, 15'h7fff);
    send_word(make_word(fnpl_pkg::ACT_PROC, 4, 53'd1 << 30, 0, 0, 0));
    send_word(make_word(fnpl_pkg::ACT_PROC, 7, '1, 2, 0, 0));

    run_phase(0, 0, 195, 15'd0, 15'd0, 15'd0);
    run_phase(68, 0, 195, 15'd16384, 15'd16384, 15'd16384);
    run_phase(0, 68, 195, 15'($urandom_range(0, 16384)), 15'($urandom_range(0, 16384)),
              15'($urandom_range(0, 16384)));
    run_phase(11, 11, 187, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
              15'($urandom_range(0, 32767)));

    drain();
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
